@@ sv/hfqb_pkg.sv @@
// Package for the heightfield query and brush block.
// Holds operation codes, register indexes, state type and default sizes.
package hfqb_pkg;

  localparam int unsigned MaxColumnsDef = 256;
  localparam int unsigned MaxRowsDef    = 256;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_BRUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_DEPTH  = 2'd1,
    REG_RADIUS = 2'd2,
    REG_ROUND  = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Q0,
    ST_Q1,
    ST_Q2,
    ST_Q3,
    ST_Q4,
    ST_QMUL,
    ST_QSUM,
    ST_QOUT,
    ST_BRD,
    ST_BWAIT,
    ST_BWR
  } state_e;

endpackage

@@ sv/heightfield_query_and_brush.sv @@
// Heightfield query and brush top level: height memory, sequencer, APB registers.
// Depends on hfqb_pkg.
//
// A write goes to the memory in its transfer cycle. A query steps through four
// corner reads from the single-port height memory (the first one also checks
// the range), a difference step, a product step, a sum and a rounding step; an
// off-grid query goes from the range check straight to the rounding step. A brush
// reads, writes back and advances per window cell, or reads and advances for a
// cell that the round test skips, over a window of up to (2R+1)^2 cells clipped
// to the grid. One item is in work at a time; a query result waits in an output
// register while later items go on, and the next query holds in its rounding
// step until that register is free. The memory holds no reset value.
module heightfield_query_and_brush #(
  parameter int unsigned MAX_COLUMNS = hfqb_pkg::MaxColumnsDef,
  parameter int unsigned MAX_ROWS    = hfqb_pkg::MaxRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_z_i,
  input  logic signed [15:0] amount_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] height_out_o,
  output logic        in_range_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hfqb_pkg::*;

  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned AW = CW + RW;
  localparam int unsigned Depth = MAX_COLUMNS * MAX_ROWS;

  // configuration
  logic [8:0] gw_cfg_q, gd_cfg_q;
  logic [7:0] rad_q;
  logic       round_q;
  logic       wr_en;
  reg_e       wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_cfg_q <= 9'd256;
      gd_cfg_q <= 9'd256;
      rad_q    <= '0;
      round_q  <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_WIDTH:  gw_cfg_q <= pwdata[8:0];
        REG_DEPTH:  gd_cfg_q <= pwdata[8:0];
        REG_RADIUS: rad_q    <= pwdata[7:0];
        REG_ROUND:  round_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_WIDTH:  prdata = {23'd0, gw_cfg_q};
      REG_DEPTH:  prdata = {23'd0, gd_cfg_q};
      REG_RADIUS: prdata = {24'd0, rad_q};
      REG_ROUND:  prdata = {31'd0, round_q};
      default:    prdata = '0;
    endcase
  end

  // clamp grid size to 2..MAX
  logic [12:0] gw, gd;
  always_comb begin
    gw = {4'd0, gw_cfg_q};
    gd = {4'd0, gd_cfg_q};
    if (gw < 13'd2) gw = 13'd2;
    if (gw > 13'(MAX_COLUMNS)) gw = 13'(MAX_COLUMNS);
    if (gd < 13'd2) gd = 13'd2;
    if (gd > 13'(MAX_ROWS)) gd = 13'(MAX_ROWS);
  end

  // item registers
  state_e state_q, state_d;
  logic [7:0]  cx_q, cz_q, fx_q, fz_q;
  logic [15:0] px_q, pz_q;
  logic signed [15:0] amt_q;
  logic [8:0]  x_q, z_q, left_q, right_q, top_q;
  logic signed [15:0] h0_q, h1_q, h2_q;
  logic signed [17:0] pa_q, pb_q;
  logic [8:0]  ma_q, mb_q;
  logic signed [26:0] m1_q, m2_q;
  logic signed [16:0] base_q;
  logic signed [27:0] acc_q;
  logic        ovalid_q;
  logic signed [15:0] hout_q;
  logic        inr_q;
  logic        inr_out_q;

  // memory
  logic signed [15:0] mem [Depth];
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic signed [15:0] mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_rd_q <= mem[mem_addr];
  end

  function automatic logic [AW-1:0] addr_of(input logic [8:0] x, input logic [8:0] z);
    logic [23:0] a;
    a = 24'(z) * 24'(MAX_COLUMNS) + 24'(x);
    return a[AW-1:0];
  endfunction

  logic accept;
  logic q_load;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;
  // load the output register once it is free or drains this cycle
  assign q_load = (state_q == ST_QOUT) && (!ovalid_q || out_ready_i);

  // brush window bounds from the incoming position
  logic [8:0] icx, icz, irad, il, ib;
  logic [9:0] ir, it;
  always_comb begin
    icx  = {1'b0, pos_x_i[15:8]};
    icz  = {1'b0, pos_z_i[15:8]};
    irad = {1'b0, rad_q};
    il   = (icx > irad) ? icx - irad : 9'd0;
    ib   = (icz > irad) ? icz - irad : 9'd0;
    ir   = {1'b0, icx} + {1'b0, irad};
    it   = {1'b0, icz} + {1'b0, irad};
    if (13'(ir) > gw - 13'd1) ir = 10'(gw - 13'd1);
    if (13'(it) > gd - 13'd1) it = 10'(gd - 13'd1);
  end

  // round-mode distance test: squared distance against squared radius, combinational
  logic signed [17:0] dx, dz;
  logic [35:0] d2;
  logic [33:0] lim2;
  logic        cell_in;
  logic [16:0] lim;
  assign dx   = $signed({1'b0, x_q, 8'd0}) - $signed({2'b0, px_q});
  assign dz   = $signed({1'b0, z_q, 8'd0}) - $signed({2'b0, pz_q});
  assign lim  = {1'b0, rad_q, 8'd0};
  assign d2   = 36'(dx) * 36'(dx) + 36'(dz) * 36'(dz);
  assign lim2 = 34'(lim) * 34'(lim);
  assign cell_in = !round_q || (d2 <= 36'(lim2));

  logic signed [16:0] bsum;
  logic signed [15:0] bsat;
  assign bsum = 17'(mem_rd_q) + 17'(amt_q);
  assign bsat = (bsum > 17'sd32767) ? 16'sh7fff :
                (bsum < -17'sd32768) ? 16'sh8000 : bsum[15:0];

  logic lower;
  assign lower = ({1'b0, fx_q} + {1'b0, fz_q}) <= 9'd256;

  logic signed [27:0] rnd;
  logic signed [19:0] hr;
  assign rnd = acc_q + 28'sd128;
  assign hr  = rnd[27:8];

  logic last_x, last_z;
  assign last_x = (x_q == right_q);
  assign last_z = (z_q == top_q);

  always_comb begin
    state_d  = state_q;
    mem_we   = 1'b0;
    mem_wd   = amt_q;
    mem_addr = addr_of(x_q, z_q);
    unique case (state_q)
      ST_IDLE: begin
        mem_addr = addr_of({1'b0, pos_x_i[15:8]}, {1'b0, pos_z_i[15:8]});
        mem_wd   = amount_i;
        if (accept) begin
          unique case (op_e'(operation_i))
            OP_WRITE: mem_we = (13'(pos_x_i[15:8]) < gw) && (13'(pos_z_i[15:8]) < gd);
            OP_QUERY: state_d = ST_Q0;
            OP_BRUSH: if (il <= 9'(ir) && ib <= 9'(it)) state_d = ST_BRD;
            default: ;
          endcase
        end
      end
      ST_Q0: begin
        if (13'(cx_q) + 13'd2 > gw || 13'(cz_q) + 13'd2 > gd) state_d = ST_QOUT;
        else begin
          mem_addr = addr_of({1'b0, cx_q}, {1'b0, cz_q});
          state_d  = ST_Q1;
        end
      end
      ST_Q1: begin mem_addr = addr_of({1'b0, cx_q}, 9'(cz_q) + 9'd1); state_d = ST_Q2; end
      ST_Q2: begin mem_addr = addr_of(9'(cx_q) + 9'd1, {1'b0, cz_q}); state_d = ST_Q3; end
      ST_Q3: begin mem_addr = addr_of(9'(cx_q) + 9'd1, 9'(cz_q) + 9'd1); state_d = ST_Q4; end
      ST_Q4: state_d = ST_QMUL;
      ST_QMUL: state_d = ST_QSUM;
      ST_QSUM: state_d = ST_QOUT;
      ST_QOUT: if (q_load) state_d = ST_IDLE;
      ST_BRD: state_d = cell_in ? ST_BWAIT : ST_BWR;
      ST_BWAIT: begin mem_we = 1'b1; mem_wd = bsat; state_d = ST_BWR; end
      ST_BWR: state_d = (last_x && last_z) ? ST_IDLE : ST_BRD;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_load) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  // datapath: capture item, corner values, products, sum, rounding
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q <= pos_x_i[15:8]; cz_q <= pos_z_i[15:8];
      fx_q <= pos_x_i[7:0];  fz_q <= pos_z_i[7:0];
      px_q <= pos_x_i; pz_q <= pos_z_i; amt_q <= amount_i;
      left_q <= il; right_q <= 9'(ir); top_q <= 9'(it);
      x_q <= il; z_q <= ib;
    end
    if (state_q == ST_BWR && !(last_x && last_z)) begin
      if (last_x) begin x_q <= left_q; z_q <= z_q + 9'd1; end
      else x_q <= x_q + 9'd1;
    end
    unique case (state_q)
      ST_Q0: inr_q <= !(13'(cx_q) + 13'd2 > gw || 13'(cz_q) + 13'd2 > gd);
      ST_Q1: h0_q <= mem_rd_q;
      ST_Q2: h1_q <= mem_rd_q;
      ST_Q3: h2_q <= mem_rd_q;
      default: ;
    endcase
    if (state_q == ST_Q4) begin
      // h3 is arriving now
      if (lower) begin
        base_q <= 17'(h0_q);
        pa_q <= 18'(h2_q) - 18'(h0_q); ma_q <= {1'b0, fx_q};
        pb_q <= 18'(h1_q) - 18'(h0_q); mb_q <= {1'b0, fz_q};
      end else begin
        base_q <= 17'(mem_rd_q);
        pa_q <= 18'(h1_q) - 18'(mem_rd_q); ma_q <= 9'd256 - 9'(fx_q);
        pb_q <= 18'(h2_q) - 18'(mem_rd_q); mb_q <= 9'd256 - 9'(fz_q);
      end
    end
    m1_q <= 27'(pa_q) * 27'($signed({1'b0, ma_q}));
    m2_q <= 27'(pb_q) * 27'($signed({1'b0, mb_q}));
    if (state_q == ST_QSUM)
      acc_q <= $signed({{3{base_q[16]}}, base_q, 8'd0}) + 28'(m1_q) + 28'(m2_q);
    if (q_load) begin
      inr_out_q <= inr_q;
      if (!inr_q) hout_q <= '0;
      else if (hr > 20'sd32767) hout_q <= 16'sh7fff;
      else if (hr < -20'sd32768) hout_q <= 16'sh8000;
      else hout_q <= hr[15:0];
    end
  end

  assign out_valid_o  = ovalid_q;
  assign height_out_o = hout_q;
  assign in_range_o   = inr_out_q;

  // hold a waiting result steady until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(height_out_o) && $stable(in_range_o))
    else $error("waiting result changed");
  // a query result follows the sequence end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QOUT) |=> out_valid_o)
    else $error("query result lost");
  // memory written only at idle or brush write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE || state_q == ST_BWAIT))
    else $error("stray memory write");
endmodule

@@ bench/testbench.sv @@
// Self-checking bench for heightfield_query_and_brush: directed and random
// writes, queries and brushes over several grid settings. Depends on hfqb_pkg.
`timescale 1ns / 100ps

module testbench;
  import hfqb_pkg::*;

  typedef struct {
    op_e             op;
    logic [15:0]     px;
    logic [15:0]     pz;
    logic signed [15:0] amt;
  } cmd_t;

  typedef struct {
    logic signed [15:0] height;
    logic               in_range;
  } sample_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, in_range_o;
  logic [1:0] operation_i;
  logic [15:0] pos_x_i, pos_z_i;
  logic signed [15:0] amount_i, height_out_o;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  heightfield_query_and_brush dut (.*);

  // Shadow copy of the height grid and the registers
  logic signed [15:0] heights [65536];
  bit          filled [65536];
  int unsigned cols_reg, rows_reg, radius_reg, round_reg;

  cmd_t    pending_cmds[$];
  sample_t heights_due[$];
  cmd_t    cur_cmd;
  int      errors, in_gap, out_gap, results_seen, hold_left;
  bit      in_fire, calm, held_once;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int unsigned cols_used();
    return (cols_reg < 2) ? 2 : (cols_reg > 256) ? 256 : cols_reg;
  endfunction

  function automatic int unsigned rows_used();
    return (rows_reg < 2) ? 2 : (rows_reg > 256) ? 256 : rows_reg;
  endfunction

  function automatic longint cell_at(int unsigned x, int unsigned z);
    return longint'(heights[(z * 256 + x) % 65536]);
  endfunction

  // Advance the shadow grid by one command; queue a height for a query
  function automatic void apply_cmd(cmd_t c);
    int unsigned gw, gd, cx, cz, fx, fz, lft, bot, rgt, top;
    longint acc, h0, h1, h2, h3, lim, dx, dz;
    sample_t s;
    gw = cols_used();
    gd = rows_used();
    cx = c.px >> 8;
    cz = c.pz >> 8;
    fx = c.px & 8'hff;
    fz = c.pz & 8'hff;
    case (c.op)
      OP_WRITE: begin
        if (cx < gw && cz < gd) heights[cz * 256 + cx] = c.amt;
      end
      OP_QUERY: begin
        if (cx + 2 > gw || cz + 2 > gd) begin
          s.height = '0;
          s.in_range = 1'b0;
        end else begin
          h0 = cell_at(cx, cz);
          h1 = cell_at(cx, cz + 1);
          h2 = cell_at(cx + 1, cz);
          h3 = cell_at(cx + 1, cz + 1);
          if (fx + fz <= 256)
            acc = 256 * h0 + (h2 - h0) * fx + (h1 - h0) * fz;
          else
            acc = 256 * h3 + (h1 - h3) * (256 - fx) + (h2 - h3) * (256 - fz);
          s.height = 16'(sat16((acc + 128) >>> 8));
          s.in_range = 1'b1;
        end
        heights_due = {heights_due, s};
      end
      OP_BRUSH: begin
        lft = (cx > radius_reg) ? cx - radius_reg : 0;
        bot = (cz > radius_reg) ? cz - radius_reg : 0;
        rgt = (cx + radius_reg > gw - 1) ? gw - 1 : cx + radius_reg;
        top = (cz + radius_reg > gd - 1) ? gd - 1 : cz + radius_reg;
        lim = longint'(radius_reg) * 256;
        for (int unsigned z = bot; z <= top; z++) begin
          for (int unsigned x = lft; x <= rgt; x++) begin
            dx = longint'(x) * 256 - longint'(c.px);
            dz = longint'(z) * 256 - longint'(c.pz);
            if (round_reg != 0 && dx * dx + dz * dz > lim * lim) continue;
            heights[z * 256 + x] = 16'(sat16(cell_at(x, z) + c.amt));
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Record each input transfer and predict its effect
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) apply_cmd(cur_cmd);
  end

  // Feed the block from the pending queue, with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        operation_i <= cur_cmd.op;
        pos_x_i <= cur_cmd.px;
        pos_z_i <= cur_cmd.pz;
        amount_i <= cur_cmd.amt;
        in_valid_i <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 18);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drive the result side: random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (!held_once && results_seen >= 60) begin
      held_once = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 18);
    end
  end

  // Check each result transfer against the oldest predicted height
  always @(posedge clk_i) begin
    sample_t s;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (heights_due.size() == 0) begin
        $error("unexpected result height %0d in_range %0b", height_out_o, in_range_o);
        errors++;
      end else begin
        s = heights_due.pop_front();
        if (height_out_o !== s.height) begin
          $error("height_out expected %0d actual %0d", s.height, height_out_o);
          errors++;
        end
        if (in_range_o !== s.in_range) begin
          $error("in_range expected %0b actual %0b", s.in_range, in_range_o);
          errors++;
        end
      end
    end
  end

  task automatic push_cmd(op_e op, int px, int pz, int amt);
    cmd_t c;
    c.op = op;
    c.px = 16'(px);
    c.pz = 16'(pz);
    c.amt = 16'(amt);
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic reg_write(reg_e idx, int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  cols_reg = val & 9'h1ff;
      REG_DEPTH:  rows_reg = val & 9'h1ff;
      REG_RADIUS: radius_reg = val & 8'hff;
      default:    round_reg = val & 1;
    endcase
  endtask

  // Hold until every command is taken, the block is idle and every result arrived
  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid_i || heights_due.size() > 0 ||
           !in_ready_o)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic int rand_amt();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  // One random command; positions mostly on the grid
  task automatic push_random();
    int unsigned gw, gd, pick, px, pz;
    gw = cols_used();
    gd = rows_used();
    pick = $urandom_range(0, 99);
    px = $urandom_range(0, gw * 256 - 1);
    pz = $urandom_range(0, gd * 256 - 1);
    if (pick % 5 == 0) begin
      px = $urandom_range(0, 65535);
      pz = $urandom_range(0, 65535);
    end
    if (pick < 40)      push_cmd(OP_QUERY, px, pz, $urandom_range(0, 65535));
    else if (pick < 65) push_cmd(OP_WRITE, px, pz, $urandom_range(0, 65535));
    else if (pick < 94) push_cmd(OP_BRUSH, px, pz, rand_amt());
    else                push_cmd(OP_NONE, px, pz, $urandom_range(0, 65535));
  endtask

  int phase_cfg[11][4] = '{
    '{4, 4, 1, 0}, '{16, 16, 3, 1}, '{2, 2, 0, 0}, '{256, 2, 255, 1},
    '{2, 256, 255, 0}, '{0, 1, 2, 1}, '{511, 2, 5, 1}, '{9, 7, 2, 1},
    '{20, 10, 4, 0}, '{13, 11, 6, 1}, '{12, 6, 2, 1}};

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    operation_i = '0;
    pos_x_i = '0;
    pos_z_i = '0;
    amount_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cols_reg = 256;
    rows_reg = 256;
    radius_reg = 0;
    round_reg = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes on the full reset grid, corners written first
    push_cmd(OP_WRITE, 16'h0000, 16'h0000, -32768);
    push_cmd(OP_WRITE, 16'h0100, 16'h0000, 32767);
    push_cmd(OP_WRITE, 16'h0000, 16'h0100, 1000);
    push_cmd(OP_WRITE, 16'h01ff, 16'h01ff, -5);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 0);
    push_cmd(OP_QUERY, 16'h0080, 16'h0080, 0);    // lower/upper boundary
    push_cmd(OP_QUERY, 16'h0081, 16'h0080, 0);
    push_cmd(OP_QUERY, 16'h00ff, 16'h00ff, 0);
    push_cmd(OP_WRITE, 16'hfe00, 16'hfe00, 32767);
    push_cmd(OP_WRITE, 16'hff00, 16'hfe00, 32767);
    push_cmd(OP_WRITE, 16'hfe00, 16'hff00, 32767);
    push_cmd(OP_WRITE, 16'hffff, 16'hffff, 32767);
    push_cmd(OP_QUERY, 16'hfeff, 16'hfeff, 0);    // last full cell
    push_cmd(OP_QUERY, 16'hff00, 16'h0000, 0);    // off grid in x
    push_cmd(OP_QUERY, 16'h0000, 16'hffff, 0);    // off grid in z
    push_cmd(OP_BRUSH, 16'h0000, 16'h0000, 32767); // brush low corner cell, radius 0
    push_cmd(OP_BRUSH, 16'h0100, 16'h0000, 32767);
    push_cmd(OP_BRUSH, 16'h0000, 16'h0100, -32768);
    push_cmd(OP_QUERY, 16'h0040, 16'h0020, 0);
    push_cmd(OP_NONE, 16'hffff, 16'hffff, -1);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 0);
    drain();

    foreach (phase_cfg[p]) begin
      reg_write(REG_WIDTH, phase_cfg[p][0]);
      reg_write(REG_DEPTH, phase_cfg[p][1]);
      reg_write(REG_RADIUS, phase_cfg[p][2]);
      reg_write(REG_ROUND, phase_cfg[p][3]);
      if (p == 10) calm = 1'b1;
      // Fill every cell of the grid not yet written so no read hits an unwritten cell
      for (int z = 0; z < int'(rows_used()); z++)
        for (int x = 0; x < int'(cols_used()); x++)
          if (!filled[z * 256 + x]) begin
            filled[z * 256 + x] = 1'b1;
            push_cmd(OP_WRITE, x * 256 + $urandom_range(0, 255),
                     z * 256 + $urandom_range(0, 255), $urandom_range(0, 65535));
          end
      repeat (30) push_random();
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
